FILE: hdl/cnts_pkg.sv
// ============================================================================
// cnts_pkg
// Shared types and constants for the calibrated nanosecond timestamp block.
// ============================================================================
package cnts_pkg;

  // Width of the operands of the shared divider.
  localparam int unsigned DIV_W = 64;

  // Nanoseconds per millisecond tick, and the largest sub-millisecond value.
  localparam int unsigned NS_PER_MS_W = 20;
  localparam logic [NS_PER_MS_W-1:0] NS_PER_MS = 20'd1000000;
  localparam logic [NS_PER_MS_W-1:0] SUB_MS_MAX = 20'd999999;

  // Register reset values.
  localparam logic [15:0] RECAL_INTERVAL_RST = 16'd100;
  localparam logic [31:0] RATE_MIN_RST = 32'd100000;
  localparam logic [31:0] RATE_MAX_RST = 32'd100000000;
  localparam logic [31:0] FALLBACK_RATE_RST = 32'd3000000;
  localparam logic [31:0] CYCLES_PER_TICK_RST = 32'd3000000;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_RECAL_INTERVAL = 2'd0,
    REG_RATE_MIN       = 2'd1,
    REG_RATE_MAX       = 2'd2,
    REG_FALLBACK_RATE  = 2'd3
  } cfg_index_t;

  typedef logic [31:0] cfg_data_t;

  typedef struct packed {
    logic [63:0] tick_count;
    logic [63:0] cycle_count;
    logic [63:0] tick_edge_cycles;
  } req_item_t;

  typedef struct packed {
    logic [63:0] time_ns;
    logic [31:0] rate_in_use;
  } rsp_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_CALIB,
    ST_RATE_DIV,
    ST_RATE_CHECK,
    ST_SUB_MUL,
    ST_SUB_START,
    ST_SUB_DIV,
    ST_TICK_MUL,
    ST_OUT
  } state_t;

endpackage

FILE: hdl/cnts_stream_if.sv
// ============================================================================
// cnts_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ============================================================================
interface cnts_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/cnts_divider.sv
// ============================================================================
// cnts_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module cnts_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [cnts_pkg::DIV_W-1:0] dividend,
  input  logic [cnts_pkg::DIV_W-1:0] divisor,
  output logic                      done,
  output logic [cnts_pkg::DIV_W-1:0] quotient
);
  import cnts_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] dvsr;
  logic [CNT_W-1:0] cnt;
  logic             active;
  logic [DIV_W:0]   rem_shift;
  logic [DIV_W:0]   trial;

  assign rem_shift = {rem, quo[DIV_W-1]};
  assign trial     = rem_shift - {1'b0, dvsr};
  assign quotient  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // The dividend shifts out of the quotient register as quotient bits enter.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (active) begin
      if (!trial[DIV_W]) begin
        rem <= trial[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: hdl/calibrated_ns_timestamp_core.sv
// ============================================================================
// calibrated_ns_timestamp_core
// Converts tick and cycle counter readings into a calibrated ns timestamp.
// ============================================================================
// Each transfer on the request channel carries the millisecond tick count,
// the cycle counter and the cycle count latched at the last tick edge. Each
// one produces exactly one transfer on the response channel with time_ns and
// the cycles-per-millisecond rate that was used.
// The block works on one request at a time and drops request.ready from
// acceptance until the response is loaded into the output register.
// Measuring the rate again adds a division, and a zero divisor skips the
// sub-millisecond division. Both use the shared one-bit-per-cycle 64-bit
// divider (64 steps per division); the shift-add multiply by 1000000 runs
// 20 steps for the sub-millisecond product and 20 for the tick product.
// The response stays in its output register while the receiver stalls; the
// next request can be accepted meanwhile, but its result waits until the
// register is free. Configuration writes through cfg_we/cfg_index/cfg_wdata
// take effect at once and are meant for idle periods only. Reset clears the
// calibration reference (the first request only records a reference point),
// sets the rate to its default and restores the register defaults.
// ============================================================================
module calibrated_ns_timestamp_core (
  input  logic                  clk,
  input  logic                  rst,
  cnts_stream_if.sink           request,
  cnts_stream_if.source         response,
  input  logic                  cfg_we,
  input  cnts_pkg::cfg_index_t  cfg_index,
  input  cnts_pkg::cfg_data_t   cfg_wdata
);
  import cnts_pkg::*;

  localparam int unsigned BIT_W = $clog2(NS_PER_MS_W);

  // Configuration registers.
  logic [15:0] recal_interval;
  logic [31:0] rate_min;
  logic [31:0] rate_max;
  logic [31:0] fallback_rate;

  // Calibration state.
  logic [31:0] cycles_per_tick;
  logic [63:0] calib_ref_tick;
  logic [63:0] calib_ref_cycles;

  // Working registers for the current request.
  logic [63:0] tick;
  logic [63:0] cycles;
  logic [63:0] edge_cycles;
  logic [63:0] dt;
  logic [63:0] dc;
  logic [63:0] delta;
  logic [63:0] acc;
  logic [63:0] mcand;
  logic [BIT_W-1:0] bit_idx;
  logic [NS_PER_MS_W-1:0] sub;
  logic [31:0] rate;

  state_t state;
  state_t state_next;

  logic             div_start;
  logic [63:0]      div_dividend;
  logic [63:0]      div_divisor;
  logic             div_done;
  logic [63:0]      div_quotient;
  logic [31:0]      divisor_sel;
  logic             mul_last;
  logic             out_free;
  logic             recal_due;
  logic             rate_ok;

  rsp_item_t   out_item;
  logic        out_valid;

  assign request.ready  = (state == ST_IDLE);
  assign response.valid = out_valid;
  assign response.data  = out_item;

  assign divisor_sel = (cycles_per_tick != 32'd0) ? cycles_per_tick : fallback_rate;
  assign mul_last    = (bit_idx == BIT_W'(NS_PER_MS_W - 1));
  assign out_free    = !out_valid || response.ready;
  assign recal_due   = (dt >= {48'd0, recal_interval});
  assign rate_ok     = (div_quotient[63:32] == 32'd0) &&
                       (div_quotient[31:0] >= rate_min) &&
                       (div_quotient[31:0] <= rate_max);

  cnts_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = acc;
    div_divisor  = {32'd0, divisor_sel};
    unique case (state)
      ST_IDLE: begin
        if (request.valid) begin
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: begin
        state_next = ST_CALIB;
      end
      ST_CALIB: begin
        state_next = ST_SUB_MUL;
        if (calib_ref_cycles != 64'd0 && recal_due && dt != 64'd0 && dc != 64'd0) begin
          div_start    = 1'b1;
          div_dividend = dc;
          div_divisor  = dt;
          state_next   = ST_RATE_DIV;
        end
      end
      ST_RATE_DIV: begin
        if (div_done) begin
          state_next = ST_RATE_CHECK;
        end
      end
      ST_RATE_CHECK: begin
        state_next = ST_SUB_MUL;
      end
      ST_SUB_MUL: begin
        if (mul_last) begin
          state_next = ST_SUB_START;
        end
      end
      ST_SUB_START: begin
        if (divisor_sel == 32'd0) begin
          state_next = ST_TICK_MUL;
        end else begin
          div_start  = 1'b1;
          state_next = ST_SUB_DIV;
        end
      end
      ST_SUB_DIV: begin
        if (div_done) begin
          state_next = ST_TICK_MUL;
        end
      end
      ST_TICK_MUL: begin
        if (mul_last) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Configuration and calibration state.
  always_ff @(posedge clk) begin
    if (rst) begin
      recal_interval   <= RECAL_INTERVAL_RST;
      rate_min         <= RATE_MIN_RST;
      rate_max         <= RATE_MAX_RST;
      fallback_rate    <= FALLBACK_RATE_RST;
      cycles_per_tick  <= CYCLES_PER_TICK_RST;
      calib_ref_tick   <= '0;
      calib_ref_cycles <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RECAL_INTERVAL: recal_interval <= cfg_wdata[15:0];
          REG_RATE_MIN:       rate_min       <= cfg_wdata;
          REG_RATE_MAX:       rate_max       <= cfg_wdata;
          REG_FALLBACK_RATE:  fallback_rate  <= cfg_wdata;
          default: ;
        endcase
      end
      // The reference point moves whenever a reference is taken or the rate
      // is measured, whether or not the measured rate is accepted.
      if (state == ST_CALIB &&
          (calib_ref_cycles == 64'd0 || (recal_due && (dt == 64'd0 || dc == 64'd0)))) begin
        calib_ref_tick   <= tick;
        calib_ref_cycles <= cycles;
      end
      if (state == ST_RATE_CHECK) begin
        calib_ref_tick   <= tick;
        calib_ref_cycles <= cycles;
        if (rate_ok) begin
          cycles_per_tick <= div_quotient[31:0];
        end
      end
    end
  end

  // Request datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (request.valid) begin
          tick        <= request.data.tick_count;
          cycles      <= request.data.cycle_count;
          edge_cycles <= request.data.tick_edge_cycles;
        end
      end
      ST_DIFF: begin
        dt    <= tick - calib_ref_tick;
        dc    <= (cycles > calib_ref_cycles) ? (cycles - calib_ref_cycles) : 64'd0;
        delta <= (cycles > edge_cycles && edge_cycles != 64'd0) ?
                 (cycles - edge_cycles) : 64'd0;
      end
      ST_CALIB, ST_RATE_CHECK: begin
        acc     <= '0;
        mcand   <= delta;
        bit_idx <= '0;
      end
      ST_SUB_MUL, ST_TICK_MUL: begin
        if (NS_PER_MS[bit_idx]) begin
          acc <= acc + mcand;
        end
        mcand   <= {mcand[62:0], 1'b0};
        bit_idx <= bit_idx + BIT_W'(1);
      end
      ST_SUB_START: begin
        rate <= divisor_sel;
        if (divisor_sel == 32'd0) begin
          sub     <= SUB_MS_MAX;
          acc     <= '0;
          mcand   <= tick;
          bit_idx <= '0;
        end
      end
      ST_SUB_DIV: begin
        if (div_done) begin
          sub     <= (div_quotient > {44'd0, SUB_MS_MAX}) ?
                     SUB_MS_MAX : div_quotient[NS_PER_MS_W-1:0];
          acc     <= '0;
          mcand   <= tick;
          bit_idx <= '0;
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && response.ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      out_item.time_ns     <= acc + {44'd0, sub};
      out_item.rate_in_use <= rate;
    end
  end

endmodule

FILE: test/calibrated_ns_timestamp_core_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// calibrated_ns_timestamp_core_tb
// Self-checking bench for the calibrated nanosecond timestamp block.
// ============================================================================
// Requests go in over the request channel and every accepted request is run
// through a local model of the calibration state to predict its timestamp and
// rate. A checker compares each response transfer with the oldest prediction.
// A directed part covers the calibration corner cases, then streams of counter
// readings that look like a real tick source, mixed with noise, run under
// several flow-control patterns and register settings.
// ============================================================================
module calibrated_ns_timestamp_core_tb;
  import cnts_pkg::*;

  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 250;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  cfg_index_t cfg_index;
  cfg_data_t  cfg_wdata;

  cnts_stream_if #(.payload_t(req_item_t)) stamp_req ();
  cnts_stream_if #(.payload_t(rsp_item_t)) stamp_rsp ();

  calibrated_ns_timestamp_core u_top (
    .clk       (clk),
    .rst       (rst),
    .request   (stamp_req),
    .response  (stamp_rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Local copy of the registers and the calibration state.
  logic [15:0] m_recal;
  logic [31:0] m_rate_min;
  logic [31:0] m_rate_max;
  logic [31:0] m_fallback;
  logic [31:0] m_cycles_per_tick;
  logic [63:0] m_ref_tick;
  logic [63:0] m_ref_cycles;

  rsp_item_t pending_stamps[$];
  int        err_cnt;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        quiet_cycles;

  // Counters of the simulated tick source used by the random streams.
  logic [63:0] src_tick;
  logic [63:0] src_cycles;
  logic [63:0] src_rate;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic rsp_item_t predict_stamp(input req_item_t rq);
    rsp_item_t   res;
    logic [63:0] dt;
    logic [63:0] dc;
    logic [63:0] rate;
    logic [63:0] delta;
    logic [63:0] sub;
    logic [31:0] div;
    if (m_ref_cycles == '0) begin
      m_ref_tick = rq.tick_count;
      m_ref_cycles = rq.cycle_count;
    end else if (rq.tick_count - m_ref_tick >= {48'd0, m_recal}) begin
      dt = rq.tick_count - m_ref_tick;
      dc = (rq.cycle_count > m_ref_cycles) ? rq.cycle_count - m_ref_cycles : '0;
      if (dt != '0 && dc != '0) begin
        rate = dc / dt;
        if (rate >= {32'd0, m_rate_min} && rate <= {32'd0, m_rate_max})
          m_cycles_per_tick = rate[31:0];
      end
      // The reference moves even when the measured rate is rejected.
      m_ref_tick = rq.tick_count;
      m_ref_cycles = rq.cycle_count;
    end
    div = (m_cycles_per_tick != '0) ? m_cycles_per_tick : m_fallback;
    delta = (rq.cycle_count > rq.tick_edge_cycles && rq.tick_edge_cycles != '0) ?
            rq.cycle_count - rq.tick_edge_cycles : '0;
    if (div == '0) begin
      sub = 64'(SUB_MS_MAX);
    end else begin
      sub = (delta * 64'(NS_PER_MS)) / {32'd0, div};
      if (sub > 64'(SUB_MS_MAX)) sub = 64'(SUB_MS_MAX);
    end
    res.time_ns = rq.tick_count * 64'(NS_PER_MS) + sub;
    res.rate_in_use = div;
    return res;
  endfunction

  // Sends one request; valid stays high afterwards so that back-to-back
  // transfers need no gap.
  task automatic send_req(input req_item_t item);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      stamp_req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    stamp_req.valid <= 1'b1;
    stamp_req.data <= item;
    do @(posedge clk); while (!stamp_req.ready);
    pending_stamps.push_back(predict_stamp(item));
  endtask

  task automatic send_fields(input logic [63:0] tick, input logic [63:0] cyc,
                             input logic [63:0] edge_cyc);
    req_item_t it;
    it.tick_count = tick;
    it.cycle_count = cyc;
    it.tick_edge_cycles = edge_cyc;
    send_req(it);
  endtask

  // Holds the sender off until every predicted response has been checked.
  task automatic wait_idle();
    stamp_req.valid <= 1'b0;
    while (pending_stamps.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] recal, input logic [31:0] rmin,
                            input logic [31:0] rmax, input logic [31:0] fallback);
    cfg_we <= 1'b1;
    cfg_index <= REG_RECAL_INTERVAL;
    cfg_wdata <= {16'd0, recal};
    @(posedge clk);
    cfg_index <= REG_RATE_MIN;
    cfg_wdata <= rmin;
    @(posedge clk);
    cfg_index <= REG_RATE_MAX;
    cfg_wdata <= rmax;
    @(posedge clk);
    cfg_index <= REG_FALLBACK_RATE;
    cfg_wdata <= fallback;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_recal = recal;
    m_rate_min = rmin;
    m_rate_max = rmax;
    m_fallback = fallback;
  endtask

  // Reference recording after reset, a first measured rate and the wrap
  // of the tick and cycle counters at their top value, all with the register defaults.
  task automatic test_reference_and_first_rate();
    send_fields('0, '0, '0);                     // reference at cycle zero
    send_fields(64'd5, 64'd1000, '0);            // first real reference
    send_fields(64'd50, 64'd2000, 64'd1500);     // interval not yet reached
    send_fields(64'd105, 64'd200_001_000, 64'd200_001_000 - 64'd1_999_999);
    send_fields(64'd106, 64'd5, 64'd10);         // cycle counter below the edge
    send_fields(64'd107, '1, 64'd1);             // product wraps, then clamps
    send_fields('1, '1, '1 - 64'd1);
    send_fields(64'd300, 64'h8000_0000_0000_0000, '0);
    wait_idle();
  endtask

  // Zero interval, zero measured rate, zero divisor and crossed bounds.
  task automatic test_calibration_corners();
    set_config(16'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
    send_fields(64'd300, 64'd5, '0);             // no elapsed ticks
    send_fields(64'd301, 64'd3, 64'd1);          // cycle counter went back
    send_fields(64'd1301, 64'd500, 64'd100);     // accepted rate of zero
    send_fields(64'd1302, 64'd900, 64'd400);
    wait_idle();
    set_config(16'hFFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_fields(64'd1301 + 64'd65535, '1, 64'd1);
    send_fields(64'd1301 + 64'd65536, 64'd1000, 64'd999);
    send_fields(64'hFFFF_FFFF_FFFF_0000, 64'hFFFF_0000_0000_0000, 64'h7FFF_0000_0000_0000);
    send_fields(64'd10, 64'd20, 64'd20);         // edge equal to the counter
    wait_idle();
  endtask

  // One request of a stream: mostly a plausible reading of a running tick
  // source, sometimes noise or a broken reading.
  task automatic send_stream_item();
    int          kind;
    logic [63:0] dtick;
    logic [63:0] rate;
    logic [63:0] edge_cyc;
    kind = $urandom_range(99);
    if (kind < 10) begin
      send_fields(rand64(), rand64(), rand64());
      return;
    end
    if (kind < 13) begin
      src_tick = rand64();
      src_cycles = rand64();
    end
    if ($urandom_range(19) == 0)
      src_rate = 64'($urandom_range(m_rate_min / 2, m_rate_max)) +
                 ($urandom_range(3) == 0 ? 64'(m_rate_max) / 2 : 64'd0) + 64'd1;
    dtick = ($urandom_range(3) == 0) ? 64'd0 :
            64'($urandom_range(1, int'(m_recal) + int'(m_recal) / 2 + 1));
    rate = src_rate + 64'($urandom_range(0, int'(src_rate / 64'd1000)));
    src_tick = src_tick + dtick;
    src_cycles = src_cycles + dtick * rate + 64'($urandom_range(0, 255));
    case ($urandom_range(19))
      0: edge_cyc = '0;
      1: edge_cyc = src_cycles + 64'($urandom_range(0, 100));
      2: edge_cyc = src_cycles - 64'd2 * rate;
      default: edge_cyc = src_cycles - 64'($urandom_range(0, int'(rate - 64'd1)));
    endcase
    if (kind < 16)
      send_fields(src_tick, src_cycles - 64'($urandom_range(1, 1000000)), edge_cyc);
    else
      send_fields(src_tick, src_cycles, edge_cyc);
  endtask

  task automatic run_stream_phase(input int idle_pct, input int stall_pct,
                                  input logic [15:0] recal, input int n);
    logic [31:0] rmin;
    logic [31:0] rmax;
    rmin = $urandom_range(100000, 2000000);
    rmax = rmin + $urandom_range(0, 50000000);
    set_config(recal, rmin, rmax, $urandom | 32'd1);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    src_tick = rand64();
    src_cycles = rand64();
    src_rate = 64'($urandom_range(rmin, rmax));
    for (int i = 0; i < n; i++) begin
      send_stream_item();
      if (i == n / 2) wait_idle();
    end
    wait_idle();
  endtask

  task automatic test_random_streams();
    run_stream_phase(0, 0, 16'd1, 95);
    run_stream_phase(84, 0, 16'($urandom_range(2, 300)), 95);
    run_stream_phase(0, 84, 16'($urandom_range(2, 300)), 95);
    run_stream_phase(30, 30, 16'($urandom_range(2, 300)), 95);
  endtask

  // Response checker and receiver flow control.
  initial begin
    rsp_item_t exp_item;
    stamp_rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && stamp_rsp.valid && stamp_rsp.ready) begin
        if (pending_stamps.size() == 0) begin
          $error("unexpected response: time_ns %0d rate_in_use %0d",
                 stamp_rsp.data.time_ns, stamp_rsp.data.rate_in_use);
          err_cnt++;
        end else begin
          exp_item = pending_stamps.pop_front();
          if (stamp_rsp.data.time_ns !== exp_item.time_ns) begin
            $error("time_ns: expected %0d, got %0d", exp_item.time_ns,
                   stamp_rsp.data.time_ns);
            err_cnt++;
          end
          if (stamp_rsp.data.rate_in_use !== exp_item.rate_in_use) begin
            $error("rate_in_use: expected %0d, got %0d", exp_item.rate_in_use,
                   stamp_rsp.data.rate_in_use);
            err_cnt++;
          end
        end
      end
      stamp_rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Ends a run that stops making progress.
  always @(posedge clk) begin
    if ((stamp_req.valid && stamp_req.ready) || (stamp_rsp.valid && stamp_rsp.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    err_cnt = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    m_recal = RECAL_INTERVAL_RST;
    m_rate_min = RATE_MIN_RST;
    m_rate_max = RATE_MAX_RST;
    m_fallback = FALLBACK_RATE_RST;
    m_cycles_per_tick = CYCLES_PER_TICK_RST;
    m_ref_tick = '0;
    m_ref_cycles = '0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_RECAL_INTERVAL;
    cfg_wdata <= '0;
    stamp_req.valid <= 1'b0;
    stamp_req.data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reference_and_first_rate();
    test_calibration_corners();
    test_random_streams();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_stamps.size() != 0) begin
      $error("%0d responses never arrived", pending_stamps.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: calibrated_ns_timestamp_core.f
hdl/cnts_pkg.sv
hdl/cnts_stream_if.sv
hdl/cnts_divider.sv
hdl/calibrated_ns_timestamp_core.sv
test/calibrated_ns_timestamp_core_tb.sv
